### rtl/pid_controller_clamped_defines.svh
// Assertion macros shared by the PID controller RTL.
// Needs a clock named clock and a synchronous active-high reset named reset in scope.
`ifndef PID_CONTROLLER_CLAMPED_DEFINES_SVH
`define PID_CONTROLLER_CLAMPED_DEFINES_SVH

// same-cycle implication
`define PIDC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pidc_pkg.sv
// Package for the clamped PID controller: widths, data types, register indexes.
// No dependencies; used by the interfaces, the divider and the top level.
`default_nettype none

package pidc_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;

   // sum of up to three saturated terms, exact
   localparam int SUM_W   = DATA_WIDTH + 2;
   // signed multiplier operand: signed value or zero-extended unsigned value
   localparam int OPND_W  = DATA_WIDTH + 1;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int SHIFT_W = PROD_W - FRAC_BITS;
   // quotient of |diff| * 2^FRAC_BITS / dt
   localparam int QUO_W   = DATA_WIDTH + 1 + FRAC_BITS;
   localparam int CNT_W   = $clog2(QUO_W);

   localparam int CSR_IDX_W = 3;

   typedef logic signed [DATA_WIDTH-1:0] data_type;
   typedef logic        [DATA_WIDTH-1:0] udata_type;

   localparam data_type DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam data_type DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_OUT_MIN   = 3'd4,
      CSR_OUT_MAX   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } pidc_div_stat_type;

endpackage

`default_nettype wire

### rtl/pidc_req_if.sv
// Input item channel: one signed error sample.
// Depends on pidc_pkg.
`default_nettype none

interface pidc_req_if import pidc_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type error_sample;

   modport source (output valid, output error_sample, input ready);
   modport sink   (input valid, input error_sample, output ready);
endinterface

`default_nettype wire

### rtl/pidc_rsp_if.sv
// Result item channel: drive value and updated integral.
// Depends on pidc_pkg.
`default_nettype none

interface pidc_rsp_if import pidc_pkg::*; ();
   logic     valid;
   logic     ready;
   data_type drive;
   data_type integral_value;

   modport source (output valid, output drive, output integral_value, input ready);
   modport sink   (input valid, input drive, input integral_value, output ready);
endinterface

`default_nettype wire

### rtl/pidc_csr_if.sv
// Register write channel: register index and write data.
// Depends on pidc_pkg.
`default_nettype none

interface pidc_csr_if import pidc_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   udata_type            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/pidc_div.sv
// Restoring divider for the derivative term: (diff * 2^FRAC_BITS) / dt, one bit a cycle.
// Depends on pidc_pkg and the assertion macro header.
`default_nettype none
`include "pid_controller_clamped_defines.svh"

module pidc_div import pidc_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic signed [DATA_WIDTH:0] diff,
   input  wire udata_type               divisor,
   output pidc_div_stat_type            stat,
   output data_type                     result
);

   typedef enum logic [1:0] {D_IDLE, D_ABS, D_RUN, D_SAT} div_state_type;

   div_state_type             state_ff;
   logic signed [DATA_WIDTH:0] diff_ff;
   udata_type                 divisor_ff;
   logic [DATA_WIDTH-1:0]     rem_ff;
   logic [QUO_W-1:0]          dvd_ff;
   logic [CNT_W-1:0]          cnt_ff;
   logic                      neg_ff;
   logic                      zero_ff;
   logic                      done_ff;
   data_type                  result_ff;

   logic [DATA_WIDTH:0]       mag_in;
   logic [DATA_WIDTH:0]       rem_sh;
   logic [DATA_WIDTH+1:0]     trial;
   logic                      qbit;
   logic                      big;

   always_comb begin
      mag_in = diff_ff[DATA_WIDTH] ? (DATA_WIDTH+1)'(-diff_ff) : diff_ff;
      rem_sh = {rem_ff, dvd_ff[QUO_W-1]};
      trial  = {1'b0, rem_sh} - {2'b00, divisor_ff};
      qbit   = ~trial[DATA_WIDTH+1];
      // quotient at or above 2^(DATA_WIDTH-1) saturates either way
      big    = |dvd_ff[QUO_W-1:DATA_WIDTH-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         // one-cycle pulse as the quotient is loaded
         done_ff <= (state_ff == D_SAT);
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  diff_ff    <= diff;
                  divisor_ff <= divisor;
                  state_ff   <= D_ABS;
               end
            end
            D_ABS: begin
               neg_ff   <= diff_ff[DATA_WIDTH];
               zero_ff  <= (diff_ff == '0);
               dvd_ff   <= {mag_in, {FRAC_BITS{1'b0}}};
               rem_ff   <= '0;
               cnt_ff   <= CNT_W'(QUO_W - 1);
               state_ff <= D_RUN;
            end
            D_RUN: begin
               rem_ff <= qbit ? trial[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
               dvd_ff <= {dvd_ff[QUO_W-2:0], qbit};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0)
                  state_ff <= D_SAT;
            end
            D_SAT: begin
               priority if (zero_ff)
                  result_ff <= '0;
               else if (big)
                  result_ff <= neg_ff ? DATA_MIN : DATA_MAX;
               else if (neg_ff)
                  result_ff <= data_type'(-dvd_ff[DATA_WIDTH-1:0]);
               else
                  result_ff <= data_type'(dvd_ff[DATA_WIDTH-1:0]);
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign stat.busy = (state_ff != D_IDLE);
   assign stat.done = done_ff;
   assign result    = result_ff;

   `PIDC_ASSERT_NOW(a_div_start_idle, start, state_ff == D_IDLE, "divider started while busy")
   `PIDC_ASSERT_NEXT(a_div_done_pulse, done_ff, !done_ff, "divider done held")
   `PIDC_ASSERT_NEXT(a_div_last_step, state_ff == D_RUN && cnt_ff == '0, state_ff == D_SAT, "divider overran")

endmodule

`default_nettype wire

### rtl/pid_controller_clamped.sv
// Clamped PID controller top level: register file, sequencer, shared multiplier.
// Depends on pidc_pkg, the channel interfaces, pidc_div and the assertion macro header.
`default_nettype none
`include "pid_controller_clamped_defines.svh"

// Discrete PID step in signed Q16.16. Each accepted error item gives one result item
// with the clamped drive and the updated integral. The integral gains
// floor(error*dt) and is clamped to [out_min, out_max]; the drive is
// kp*error + ki*integral + kd*(error - previous)/dt, each product floored and
// saturated, the quotient truncated toward zero and saturated, the sum clamped.
// When out_min > out_max, anything >= out_max gives out_max, all else out_min.
// A zero dt makes the derivative quotient saturate by the sign of the error change.
// The 49-step restoring divider for the derivative sets the time per item; the four
// products share one 33x33 signed multiplier, the kd product once the quotient is in.
// req_if.ready is high only while the block is idle. A finished result sits in
// the output register, so the next item can be taken before it is collected.
// Register writes are always ready; writes to indexes past out_max are dropped.

module pid_controller_clamped import pidc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   pidc_req_if.sink   req_if,
   pidc_rsp_if.source rsp_if,
   pidc_csr_if.sink   csr_if
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_MDT,    // issue err * dt, start divider
      S_MGP,    // issue err * kp
      S_INTEG,  // new integral from err * dt
      S_MGI,    // issue integral * ki, sum = kp term
      S_WGI,
      S_ADDI,   // sum += ki term
      S_DWAIT,  // wait quotient, issue deriv * kd
      S_WGD,
      S_ADDD,   // sum += kd term
      S_DRIVE   // clamp, load result register
   } state_type;

   state_type          state_ff;

   // registers
   udata_type          gain_p_ff;
   udata_type          gain_i_ff;
   udata_type          gain_d_ff;
   udata_type          time_step_ff;
   data_type           out_min_ff;
   data_type           out_max_ff;

   // controller state
   data_type           integ_acc_ff;
   data_type           prev_err_ff;

   // working registers
   data_type           err_ff;
   data_type           integ_ff;
   logic signed [PROD_W-1:0] prod_ff;
   data_type           term_ff;
   logic signed [SUM_W-1:0]  sum_ff;

   // result register
   logic               rsp_valid_ff;
   data_type           rsp_drive_ff;
   data_type           rsp_integ_ff;

   // shared multiplier operands
   data_type           mul_a;
   udata_type          mul_b;

   // divider
   logic                    div_start;
   logic signed [DATA_WIDTH:0] div_diff;
   pidc_div_stat_type       div_stat;
   data_type                div_result;

   logic               rsp_free;

   // floor(p / 2^FRAC_BITS), saturated to the data range
   function automatic data_type sat_prod(input logic signed [PROD_W-1:0] p);
      logic [SHIFT_W-1:0] sh;
      sh = p[PROD_W-1:FRAC_BITS];
      if (&sh[SHIFT_W-1:DATA_WIDTH-1] || ~|sh[SHIFT_W-1:DATA_WIDTH-1])
         return data_type'(sh[DATA_WIDTH-1:0]);
      else
         return sh[SHIFT_W-1] ? DATA_MIN : DATA_MAX;
   endfunction

   // upper limit wins, so crossed limits collapse to one of the two
   function automatic data_type clamp_val(input logic signed [SUM_W-1:0] v,
                                          input data_type lo, input data_type hi);
      priority if (v >= SUM_W'(hi))
         return hi;
      else if (v <= SUM_W'(lo))
         return lo;
      else
         return data_type'(v[DATA_WIDTH-1:0]);
   endfunction

   // ---------------------------------------------------------------- registers
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= udata_type'(1) << FRAC_BITS;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         time_step_ff <= udata_type'(1) << FRAC_BITS;
         out_min_ff   <= DATA_MIN;
         out_max_ff   <= DATA_MAX;
      end else if (csr_if.valid) begin
         unique case (csr_index_type'(csr_if.index))
            CSR_GAIN_P:    gain_p_ff    <= csr_if.data;
            CSR_GAIN_I:    gain_i_ff    <= csr_if.data;
            CSR_GAIN_D:    gain_d_ff    <= csr_if.data;
            CSR_TIME_STEP: time_step_ff <= csr_if.data;
            CSR_OUT_MIN:   out_min_ff   <= data_type'(csr_if.data);
            CSR_OUT_MAX:   out_max_ff   <= data_type'(csr_if.data);
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------- derivative divide
   assign div_start = (state_ff == S_MDT);
   assign div_diff  = (DATA_WIDTH+1)'(err_ff) - (DATA_WIDTH+1)'(prev_err_ff);

   pidc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .diff    (div_diff),
      .divisor (time_step_ff),
      .stat    (div_stat),
      .result  (div_result)
   );

   // ---------------------------------------------------------- shared multiplier
   // two-stage: product register, then floor/saturate register
   always_comb begin
      unique case (state_ff)
         S_MDT: begin
            mul_a = err_ff;
            mul_b = time_step_ff;
         end
         S_MGI: begin
            mul_a = integ_ff;
            mul_b = gain_i_ff;
         end
         S_DWAIT: begin
            mul_a = div_result;
            mul_b = gain_d_ff;
         end
         default: begin
            mul_a = err_ff;
            mul_b = gain_p_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed({mul_a[DATA_WIDTH-1], mul_a}) * $signed({1'b0, mul_b});
      term_ff <= sat_prod(prod_ff);
   end

   // ---------------------------------------------------------------- sequencer
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         integ_acc_ff <= '0;
         prev_err_ff  <= '0;
      end else begin
         // a new result replaces one collected in the same cycle
         if (state_ff == S_DRIVE && rsp_free)
            rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp_if.ready)
            rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            S_IDLE: begin
               if (req_if.valid) begin
                  err_ff   <= req_if.error_sample;
                  state_ff <= S_MDT;
               end
            end
            S_MDT:   state_ff <= S_MGP;
            S_MGP:   state_ff <= S_INTEG;
            S_INTEG: begin
               integ_ff <= clamp_val(SUM_W'(integ_acc_ff) + SUM_W'(term_ff),
                                     out_min_ff, out_max_ff);
               state_ff <= S_MGI;
            end
            S_MGI: begin
               sum_ff   <= SUM_W'(term_ff);
               state_ff <= S_WGI;
            end
            S_WGI:   state_ff <= S_ADDI;
            S_ADDI: begin
               sum_ff   <= sum_ff + SUM_W'(term_ff);
               state_ff <= S_DWAIT;
            end
            S_DWAIT: begin
               if (div_stat.done)
                  state_ff <= S_WGD;
            end
            S_WGD:   state_ff <= S_ADDD;
            S_ADDD: begin
               sum_ff   <= sum_ff + SUM_W'(term_ff);
               state_ff <= S_DRIVE;
            end
            S_DRIVE: begin
               // hold here until the result register is free
               if (rsp_free) begin
                  rsp_drive_ff <= clamp_val(sum_ff, out_min_ff, out_max_ff);
                  rsp_integ_ff <= integ_ff;
                  integ_acc_ff <= integ_ff;
                  prev_err_ff  <= err_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.drive          = rsp_drive_ff;
   assign rsp_if.integral_value = rsp_integ_ff;

   // ---------------------------------------------------------------- checks
   `PIDC_ASSERT_NOW(a_done_in_wait, div_stat.done, state_ff == S_DWAIT, "quotient arrived outside wait")
   `PIDC_ASSERT_NOW(a_div_idle, state_ff == S_IDLE, !div_stat.busy, "divider busy while idle")
   `PIDC_ASSERT_NEXT(a_integ_limits, state_ff == S_INTEG && out_min_ff <= out_max_ff, integ_ff >= $past(out_min_ff) && integ_ff <= $past(out_max_ff), "integral outside limits")
   `PIDC_ASSERT_NEXT(a_drive_limits, state_ff == S_DRIVE && rsp_free && out_min_ff <= out_max_ff, rsp_drive_ff >= $past(out_min_ff) && rsp_drive_ff <= $past(out_max_ff), "drive outside limits")

endmodule

`default_nettype wire

### test/tb.sv
// Self-checking testbench for the clamped PID controller.
// Uses pidc_pkg, the three channel interfaces and the pid_controller_clamped top level.
`timescale 1ns / 100ps

module tb;
   import pidc_pkg::*;

   // handshake-free stretch that counts as a hang; the slowest legal gap is the
   // long output hold plus the processing of the items held behind it
   localparam int WATCHDOG_LIMIT = 2000;
   // acceptance to result, plus margin
   localparam int LATENCY        = 57;
   localparam int SWEEP_PHASES   = 12;
   localparam int PHASE_ITEMS    = 50;
   localparam int HOLD_CYCLES    = 400;

   // indexes past out_max: the block drops these writes
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   localparam udata_type Q_ONE = udata_type'(1) << FRAC_BITS;
   localparam udata_type U_MAX = '1;

   typedef struct {
      data_type drive;
      data_type integral;
   } pid_result_type;

   logic clock;
   logic reset;

   pidc_req_if req_if ();
   pidc_rsp_if rsp_if ();
   pidc_csr_if csr_if ();

   pid_controller_clamped i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   // ---------------------------------------------------------------------
   // Controller mirror: register copy and loop state
   // ---------------------------------------------------------------------
   udata_type kp      = Q_ONE;
   udata_type ki      = '0;
   udata_type kd      = '0;
   udata_type dt_reg  = Q_ONE;
   data_type  lim_lo  = DATA_MIN;
   data_type  lim_hi  = DATA_MAX;
   data_type  integ_acc = '0;
   data_type  prev_err  = '0;

   pid_result_type expected_results[$];

   // bookkeeping
   int items_sent     = 0;
   int results_seen   = 0;
   int reg_writes     = 0;
   int mismatches     = 0;
   int idle_cycles    = 0;

   // idling controls
   bit req_idling = 1'b1;
   bit rsp_idling = 1'b1;
   int rsp_gap    = 0;
   int rsp_hold   = 0;

   data_type walk_err = '0;

   wire req_fire = req_if.valid && req_if.ready;
   wire rsp_fire = rsp_if.valid && rsp_if.ready;
   wire csr_fire = csr_if.valid && csr_if.ready;

   // saturate a wide signed value to the data range
   function automatic data_type saturate(input logic signed [65:0] v);
      if (v > 66'(DATA_MAX)) return DATA_MAX;
      if (v < 66'(DATA_MIN)) return DATA_MIN;
      return v[DATA_WIDTH-1:0];
   endfunction

   // floor(value * factor / 2^FRAC_BITS), saturated; factor is unsigned
   function automatic data_type scaled_product(input longint value, input udata_type factor);
      logic signed [65:0] prod;
      prod = 66'(value) * $signed({34'd0, factor});
      return saturate(prod >>> FRAC_BITS);
   endfunction

   // diff * 2^FRAC_BITS / step, truncated toward zero, saturated;
   // a zero step pins the result by the sign of diff
   function automatic data_type rate_quotient(input longint diff, input udata_type step);
      logic [63:0]        mag;
      logic [63:0]        quo;
      logic signed [65:0] wide;
      if (diff == 0) return '0;
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      if (step == '0) quo = '1;
      else quo = (mag << FRAC_BITS) / 64'(step);
      wide = {2'b00, quo};
      return saturate((diff < 0) ? -wide : wide);
   endfunction

   // upper limit wins, so crossed limits give out_max or out_min only
   function automatic data_type clamp_to_limits(input longint v);
      if (v >= longint'(lim_hi)) return lim_hi;
      if (v <= longint'(lim_lo)) return lim_lo;
      return data_type'(v);
   endfunction

   // one control step: updates integral and previous error, returns the result
   function automatic pid_result_type advance_controller(input data_type err);
      pid_result_type res;
      data_type    integ;
      data_type    deriv;
      longint      sum;
      integ = clamp_to_limits(longint'(integ_acc) + longint'(scaled_product(err, dt_reg)));
      deriv = rate_quotient(longint'(err) - longint'(prev_err), dt_reg);
      sum   = longint'(scaled_product(err, kp)) + longint'(scaled_product(integ, ki))
            + longint'(scaled_product(deriv, kd));
      res.drive    = clamp_to_limits(sum);
      res.integral = integ;
      integ_acc    = integ;
      prev_err     = err;
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------

   // write one register; the mirror follows at the accepting edge
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input udata_type value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         CSR_GAIN_P:    kp     = value;
         CSR_GAIN_I:    ki     = value;
         CSR_GAIN_D:    kd     = value;
         CSR_TIME_STEP: dt_reg = value;
         CSR_OUT_MIN:   lim_lo = data_type'(value);
         CSR_OUT_MAX:   lim_hi = data_type'(value);
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // offer one error item, after a random gap if req_idling is set; valid is
   // left high, so a back-to-back item keeps it up without a glitch
   task automatic send_error_item(input data_type err);
      int gap;
      gap = req_idling ? $urandom_range(7, 0) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.error_sample <= err;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_results.push_back(advance_controller(err));
      items_sent++;
   endtask

   // stop offering and wait for every outstanding result; the block is idle after
   task automatic wait_results_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Result receiver: random per-item stalls plus an optional long hold
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold--;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // result checker: compare against the oldest prediction, field by field
   pid_result_type want;
   always @(posedge clock) begin
      if (!reset && rsp_fire) begin
         if (expected_results.size() == 0) begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got drive %0d integral %0d",
                     $time, rsp_if.drive, rsp_if.integral_value);
         end else begin
            want = expected_results.pop_front();
            if (rsp_if.drive !== want.drive) begin
               mismatches++;
               $display("%0t: drive mismatch, expected %0d, got %0d",
                        $time, want.drive, rsp_if.drive);
            end
            if (rsp_if.integral_value !== want.integral) begin
               mismatches++;
               $display("%0t: integral mismatch, expected %0d, got %0d",
                        $time, want.integral, rsp_if.integral_value);
            end
         end
         results_seen++;
         rsp_gap = rsp_idling ? $urandom_range(7, 0) : 0;
      end
   end

   // watchdog: any accepted item on any channel restarts the count
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire || csr_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, expected_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset values: unity kp, no i/d, full range; integral saturates at the rails
   task automatic test_reset_defaults();
      send_error_item('0);
      send_error_item(DATA_MAX);
      send_error_item(DATA_MAX);
      send_error_item(DATA_MIN);
      send_error_item(DATA_MIN);
      send_error_item(data_type'(Q_ONE));
      send_error_item(-data_type'(Q_ONE));
      wait_results_drained();
   endtask

   // zero dt: integral frozen, derivative pinned by the sign of the change,
   // and zero when the error repeats
   task automatic test_zero_time_step();
      write_reg(CSR_GAIN_P, '0);
      write_reg(CSR_GAIN_D, Q_ONE);
      write_reg(CSR_TIME_STEP, '0);
      send_error_item(data_type'(3 * Q_ONE));
      send_error_item(data_type'(3 * Q_ONE));
      send_error_item(-data_type'(5 * Q_ONE));
      wait_results_drained();
   endtask

   // crossed limits, then equal limits
   task automatic test_crossed_limits();
      write_reg(CSR_GAIN_P, Q_ONE);
      write_reg(CSR_GAIN_D, '0);
      write_reg(CSR_TIME_STEP, Q_ONE);
      write_reg(CSR_OUT_MIN, udata_type'(100 * Q_ONE));
      write_reg(CSR_OUT_MAX, udata_type'(-data_type'(100 * Q_ONE)));
      send_error_item('0);
      send_error_item(data_type'(200 * Q_ONE));
      send_error_item(-data_type'(100 * Q_ONE));
      // limits change only once the block is empty
      wait_results_drained();
      write_reg(CSR_OUT_MIN, udata_type'(7 * Q_ONE));
      write_reg(CSR_OUT_MAX, udata_type'(7 * Q_ONE));
      send_error_item(data_type'(1));
      send_error_item(DATA_MIN);
      wait_results_drained();
   endtask

   // all gains at max, smallest and largest dt: the terms saturate for full-scale errors
   task automatic test_extreme_gains();
      write_reg(CSR_GAIN_P, U_MAX);
      write_reg(CSR_GAIN_I, U_MAX);
      write_reg(CSR_GAIN_D, U_MAX);
      write_reg(CSR_TIME_STEP, udata_type'(1));
      write_reg(CSR_OUT_MIN, udata_type'(DATA_MIN));
      write_reg(CSR_OUT_MAX, udata_type'(DATA_MAX));
      send_error_item(DATA_MAX);
      send_error_item(DATA_MIN);
      send_error_item(data_type'(1));
      send_error_item(data_type'(-1));
      wait_results_drained();
      write_reg(CSR_TIME_STEP, U_MAX);
      send_error_item(DATA_MIN);
      send_error_item(DATA_MAX);
      wait_results_drained();
   endtask

   // writes past out_max must leave the registers alone
   task automatic test_spare_index();
      write_reg(CSR_GAIN_P, Q_ONE >> 1);
      write_reg(CSR_SPARE_A, '0);
      write_reg(CSR_SPARE_B, U_MAX);
      send_error_item(data_type'(2 * Q_ONE));
      send_error_item(-data_type'(Q_ONE + 1));
      wait_results_drained();
   endtask

   // receiver holds off long enough for the block to fill and stall its input,
   // then the sender pauses until everything is back before offering more
   task automatic test_output_backpressure();
      int n;
      write_reg(CSR_GAIN_I, Q_ONE >> 2);
      write_reg(CSR_GAIN_D, Q_ONE >> 3);
      write_reg(CSR_TIME_STEP, Q_ONE >> 4);
      req_idling = 1'b0;
      @(posedge clock);
      rsp_hold = HOLD_CYCLES;
      for (n = 0; n < 8; n++) send_error_item(data_type'($urandom));
      wait_results_drained();
      req_idling = 1'b1;
      for (n = 0; n < 4; n++) send_error_item(data_type'($urandom_range(4 * Q_ONE, 0)));
      wait_results_drained();
   endtask

   function automatic udata_type draw_gain();
      case ($urandom_range(5, 0))
         0:       return '0;
         1:       return U_MAX;
         2:       return $urandom_range(2 * Q_ONE, 0);
         3:       return $urandom;
         4:       return $urandom_range(Q_ONE >> 4, 0);
         default: return $urandom_range(16 * Q_ONE, Q_ONE >> 4);
      endcase
   endfunction

   // new settings for a sweep phase; the block is idle when this runs
   task automatic configure_phase(input int phase);
      udata_type step;
      data_type  a;
      data_type  b;
      data_type  k;
      case ($urandom_range(4, 0))
         0:       step = udata_type'(1);
         1:       step = U_MAX;
         2:       step = Q_ONE;
         3:       step = $urandom_range(4 * Q_ONE, Q_ONE >> 6);
         default: begin
            step = $urandom;
            if (step == '0) step = udata_type'(1);
         end
      endcase
      a = data_type'($urandom);
      b = data_type'($urandom);
      case ($urandom_range(4, 0))
         0: begin a = DATA_MIN; b = DATA_MAX; end
         1: if (a > b) begin k = a; a = b; b = k; end
         2: begin
            k = data_type'($urandom_range(64 * Q_ONE, 1));
            a = -k;
            b = k;
         end
         3: if (a < b) begin k = a; a = b; b = k; end   // crossed
         default: begin
            a = data_type'($urandom_range(8 * Q_ONE, 0)) - data_type'(4 * Q_ONE);
            b = a;
         end
      endcase
      write_reg(CSR_GAIN_P, draw_gain());
      write_reg(CSR_GAIN_I, draw_gain());
      write_reg(CSR_GAIN_D, draw_gain());
      write_reg(CSR_TIME_STEP, step);
      write_reg(CSR_OUT_MIN, udata_type'(a));
      write_reg(CSR_OUT_MAX, udata_type'(b));
      if ($urandom_range(3, 0) == 0)
         write_reg($urandom_range(1, 0) ? CSR_SPARE_A : CSR_SPARE_B, $urandom);
      // every fourth phase runs flat out on both sides
      if (phase % 4 == 3) begin
         req_idling = 1'b0;
         rsp_idling = 1'b0;
      end else begin
         req_idling = ($urandom_range(3, 0) != 0);
         rsp_idling = ($urandom_range(3, 0) != 0);
      end
   endtask

   // random phases: mostly smooth or small errors so the clamps and the
   // derivative stay interesting, with full-range noise mixed in
   task automatic test_random_sweep();
      int       phase;
      int       n;
      int       err_mode;
      data_type err;
      for (phase = 0; phase < SWEEP_PHASES; phase++) begin
         configure_phase(phase);
         err_mode = $urandom_range(3, 0);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            case (err_mode)
               0: err = data_type'($urandom);
               1: err = data_type'($urandom_range(16 * Q_ONE, 0)) - data_type'(8 * Q_ONE);
               2: begin
                  walk_err = walk_err + data_type'($urandom_range(Q_ONE, 0))
                           - data_type'(Q_ONE >> 1);
                  err = walk_err;
               end
               default: begin
                  case ($urandom_range(3, 0))
                     0:       err = DATA_MAX;
                     1:       err = DATA_MIN;
                     2:       err = '0;
                     default: err = data_type'($urandom);
                  endcase
               end
            endcase
            if ($urandom_range(9, 0) == 0) err = data_type'($urandom);
            send_error_item(err);
         end
         wait_results_drained();
      end
   endtask

   // ---------------------------------------------------------------------
   // Clock, reset and sequence
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.error_sample = '0;
      csr_if.valid        = 1'b0;
      csr_if.index        = CSR_GAIN_P;
      csr_if.data         = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_zero_time_step();
      test_crossed_limits();
      test_extreme_gains();
      test_spare_index();
      test_output_backpressure();
      test_random_sweep();

      wait_results_drained();
      // let any stray result show up
      repeat (2 * LATENCY) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches++;
         $display("%0t: %0d results never arrived", $time, expected_results.size());
      end

      $display("Run: %0d error items, %0d results, %0d register writes, %0d mismatches",
               items_sent, results_seen, reg_writes, mismatches);
      $display("Covered reset values, zero dt, crossed/equal limits, max gains, spare %s",
               "indexes, output stall and random sweeps");
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
